>>> rtl/padis_pkg.sv
// Shared types and codes for the packed array insert/delete/search block.
package padis_pkg;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_DELETE = 2'd1,
		OP_FIND   = 2'd2,
		OP_READ   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_MISSING = 2'd2,
		ST_BADPOS  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE = 2'd0,
		S_CMP  = 2'd1,
		S_UPD  = 2'd2
	} state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic load;     // capture the request fields
		logic capture;  // register the per-cell match flags
		logic commit;   // apply the update and load the result register
	} cmd_t;

	localparam int POS_W    = 6;
	localparam int VALUE_W  = 32;
	localparam int INDEX_W  = 5;
	localparam int COUNT_W  = 6;

endpackage

>>> rtl/padis_ctrl.sv
// Controller state machine: request sequencing and output handshake.
module padis_ctrl import padis_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	output logic   in_ready,
	output logic   out_valid,
	input  logic   out_ready,
	output cmd_t   cmd,
	output state_t state
);

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		out_free    = !out_valid_q || out_ready;
		in_ready    = 1'b0;
		cmd         = '0;
		state_d     = state_q;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
				if (in_valid)
					state_d = S_CMP;
			end
			S_CMP: begin
				cmd.capture = 1'b1;
				state_d     = S_UPD;
			end
			S_UPD: begin
				// hold until the result register can take the transaction
				if (out_free) begin
					cmd.commit = 1'b1;
					in_ready   = 1'b1;
					cmd.load   = in_valid;
					state_d    = in_valid ? S_CMP : S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign state     = state_q;

endmodule

>>> rtl/padis_dp.sv
// Datapath: row of entry cells with parallel compare and shift, count and result register.
module padis_dp import padis_pkg::*; #(
	parameter int DEPTH = 32,
	localparam int CW = $clog2(DEPTH + 1),
	localparam int IW = $clog2(DEPTH),
	localparam int PW = (CW > POS_W) ? CW : POS_W
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  cmd_t                      cmd,
	input  logic [1:0]                op,
	input  logic [POS_W-1:0]          position,
	input  logic signed [VALUE_W-1:0] item_value,
	output logic [1:0]                status,
	output logic [INDEX_W-1:0]        found_index,
	output logic signed [VALUE_W-1:0] read_data,
	output logic [COUNT_W-1:0]        entry_count,
	output logic [CW-1:0]             count
);

	op_t                      op_q;
	logic [POS_W-1:0]         pos_q;
	logic [VALUE_W-1:0]       val_q;
	logic [VALUE_W-1:0]       cells_q [DEPTH];
	logic [DEPTH-1:0]         match_q;
	logic [CW-1:0]            count_q;

	status_t                  status_q;
	logic [INDEX_W-1:0]       index_q;
	logic [VALUE_W-1:0]       data_q;

	logic                     hit_any;
	logic [IW-1:0]            hit_idx;
	logic [PW-1:0]            pos_ext;
	logic [PW-1:0]            cnt_ext;
	logic                     full;
	logic [VALUE_W-1:0]       rd_word;
	status_t                  st_d;
	logic [INDEX_W-1:0]       idx_d;
	logic [VALUE_W-1:0]       data_d;
	logic [CW-1:0]            cnt_d;
	logic                     do_ins;
	logic                     do_del;

	always_comb begin
		hit_any = |match_q;
		hit_idx = '0;
		// last set flag wins
		for (int k = 0; k < DEPTH; k++)
			if (match_q[k])
				hit_idx = IW'(k);
		pos_ext = PW'(pos_q);
		cnt_ext = PW'(count_q);
		full    = (count_q == CW'(DEPTH));
		rd_word = '0;
		for (int k = 0; k < DEPTH; k++)
			if (PW'(k) == pos_ext)
				rd_word = cells_q[k];
	end

	always_comb begin
		st_d   = ST_OK;
		idx_d  = '0;
		data_d = '0;
		cnt_d  = count_q;
		do_ins = 1'b0;
		do_del = 1'b0;
		unique case (op_q)
			OP_INSERT: begin
				if (full)
					st_d = ST_FULL;
				else if (pos_ext > cnt_ext)
					st_d = ST_BADPOS;
				else begin
					do_ins = 1'b1;
					cnt_d  = count_q + CW'(1);
				end
			end
			OP_DELETE: begin
				if (!hit_any)
					st_d = ST_MISSING;
				else begin
					idx_d  = INDEX_W'(hit_idx);
					do_del = 1'b1;
					cnt_d  = count_q - CW'(1);
				end
			end
			OP_FIND: begin
				if (!hit_any)
					st_d = ST_MISSING;
				else
					idx_d = INDEX_W'(hit_idx);
			end
			OP_READ: begin
				if (pos_ext >= cnt_ext)
					st_d = ST_BADPOS;
				else
					data_d = rd_word;
			end
			default: begin
				st_d = ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.commit) begin
			count_q <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= op_t'(op);
			pos_q <= position;
			val_q <= item_value;
		end
		if (cmd.capture)
			for (int k = 0; k < DEPTH; k++)
				match_q[k] <= (cells_q[k] == val_q) && (CW'(k) < count_q);
		if (cmd.commit) begin
			status_q <= st_d;
			index_q  <= idx_d;
			data_q   <= data_d;
		end
	end

	// Cell row: insert shifts up above the position, delete closes the gap downward
	always_ff @(posedge clk) begin
		if (cmd.commit && do_ins) begin
			for (int k = 1; k < DEPTH; k++)
				if (PW'(k) > pos_ext)
					cells_q[k] <= cells_q[k-1];
			for (int k = 0; k < DEPTH; k++)
				if (PW'(k) == pos_ext)
					cells_q[k] <= val_q;
		end
		if (cmd.commit && do_del) begin
			for (int k = 0; k < DEPTH - 1; k++)
				if (IW'(k) >= hit_idx)
					cells_q[k] <= cells_q[k+1];
		end
	end

	assign status      = status_q;
	assign found_index = index_q;
	assign read_data   = data_q;
	assign entry_count = COUNT_W'(count_q);
	assign count       = count_q;

endmodule

>>> rtl/packed_array_insert_delete_search_top.sv
// Top level of the packed array insert/delete/search block.
//
// Keeps a packed list of up to DEPTH signed 32-bit entries and a count.
// Input channel (in_valid/in_ready) carries op, position and item_value;
// output channel (out_valid/out_ready) returns status, found_index,
// read_data and entry_count, one result transaction per request.
// A request passes a compare state, which checks item_value against every
// cell in parallel and registers the match flags, and an update state, which
// applies the shift and loads the result register; a new request is taken no
// sooner than the last one commits. The cell row shifts all entries at once,
// so the two-step compare/update sequence sets the rate.
// The result register parts the channels: a request can be accepted while
// the previous result waits; if the receiver stalls, the update of the next
// request holds until the pending result is taken.
// Reset clears the count and the handshake state; cell contents are
// undefined until written and are never read above the count.
module packed_array_insert_delete_search_top import padis_pkg::*; #(
	parameter int DEPTH = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [1:0]                op,
	input  logic [POS_W-1:0]          position,
	input  logic signed [VALUE_W-1:0] item_value,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [1:0]                status,
	output logic [INDEX_W-1:0]        found_index,
	output logic signed [VALUE_W-1:0] read_data,
	output logic [COUNT_W-1:0]        entry_count
);

	localparam int CW = $clog2(DEPTH + 1);

	cmd_t          cmd;
	state_t        state;
	logic [CW-1:0] count;

	padis_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.state     (state)
	);

	padis_dp #(.DEPTH(DEPTH)) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.op          (op),
		.position    (position),
		.item_value  (item_value),
		.status      (status),
		.found_index (found_index),
		.read_data   (read_data),
		.entry_count (entry_count),
		.count       (count)
	);

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count <= CW'(DEPTH))
		else $error("entry count exceeds depth");

	a_accept_to_cmp: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state == S_CMP))
		else $error("accepted transaction did not enter compare");

	a_commit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> out_valid)
		else $error("commit did not present a result");

	a_count_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.commit |=> $stable(count))
		else $error("count changed without a commit");

endmodule

>>> tb/sv/tb_packed_array_insert_delete_search_top.sv
// Self-checking testbench for the packed array insert/delete/search block.
`timescale 1ns / 1ps

module tb_packed_array_insert_delete_search_top;
	import padis_pkg::*;

	localparam int DEPTH = 32;
	localparam int HOLD_CYCLES = 80;

	typedef struct packed {
		status_t                   status;
		logic [INDEX_W-1:0]        found_index;
		logic signed [VALUE_W-1:0] read_data;
		logic [COUNT_W-1:0]        entry_count;
	} response_t;

	logic                      clk;
	logic                      arst_n;
	logic                      in_valid;
	logic                      in_ready;
	logic [1:0]                op;
	logic [POS_W-1:0]          position;
	logic signed [VALUE_W-1:0] item_value;
	logic                      out_valid;
	logic                      out_ready;
	logic [1:0]                status;
	logic [INDEX_W-1:0]        found_index;
	logic signed [VALUE_W-1:0] read_data;
	logic [COUNT_W-1:0]        entry_count;

	// Shadow copy of the list, updated as each request transaction is accepted
	logic signed [VALUE_W-1:0] list_mem [DEPTH];
	int                        list_len;
	response_t                 pending_results [$];
	response_t                 check_want;
	int                        mismatch_count;
	bit                        idle_on;
	bit                        hold_req;

	packed_array_insert_delete_search_top #(
		.DEPTH(DEPTH)
	) u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.op         (op),
		.position   (position),
		.item_value (item_value),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.found_index(found_index),
		.read_data  (read_data),
		.entry_count(entry_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("FAIL");
		$finish;
	end

	function automatic int last_match(input logic signed [VALUE_W-1:0] v);
		int hit;
		hit = -1;
		for (int k = 0; k < list_len; k++) begin
			if (list_mem[k] == v)
				hit = k;
		end
		return hit;
	endfunction

	function automatic response_t predict_response(input op_t o, input logic [POS_W-1:0] p,
			input logic signed [VALUE_W-1:0] v);
		response_t rsp;
		int hit;
		rsp.status = ST_OK;
		rsp.found_index = '0;
		rsp.read_data = '0;
		case (o)
			OP_INSERT: begin
				// full is checked ahead of the position
				if (list_len >= DEPTH) begin
					rsp.status = ST_FULL;
				end else if (int'(p) > list_len) begin
					rsp.status = ST_BADPOS;
				end else begin
					for (int k = list_len; k > int'(p); k--)
						list_mem[k] = list_mem[k-1];
					list_mem[p] = v;
					list_len++;
				end
			end
			OP_DELETE: begin
				hit = last_match(v);
				if (hit < 0) begin
					rsp.status = ST_MISSING;
				end else begin
					rsp.found_index = INDEX_W'(hit);
					for (int k = hit; k + 1 < list_len; k++)
						list_mem[k] = list_mem[k+1];
					list_len--;
				end
			end
			OP_FIND: begin
				hit = last_match(v);
				if (hit < 0)
					rsp.status = ST_MISSING;
				else
					rsp.found_index = INDEX_W'(hit);
			end
			default: begin
				if (int'(p) >= list_len)
					rsp.status = ST_BADPOS;
				else
					rsp.read_data = list_mem[p];
			end
		endcase
		rsp.entry_count = COUNT_W'(list_len);
		return rsp;
	endfunction

	function automatic logic signed [VALUE_W-1:0] pool_value(input int k);
		case (k)
			0: return 32'sh0000_0000;
			1: return -32'sd1;
			2: return 32'sh7fff_ffff;
			3: return 32'sh8000_0000;
			4: return 32'sd1;
			5: return 32'sh5a5a_5a5a;
			6: return 32'sha5a5_a5a5;
			default: return 32'sd42;
		endcase
	endfunction

	// Mostly values that can hit the list, so find and delete reach deep indices
	function automatic logic signed [VALUE_W-1:0] pick_value();
		int r;
		r = $urandom_range(99);
		if (r < 40)
			return pool_value($urandom_range(7));
		if (r < 75 && list_len > 0)
			return list_mem[$urandom_range(list_len - 1)];
		return $urandom;
	endfunction

	task automatic send_request(input op_t o, input logic [POS_W-1:0] p,
			input logic signed [VALUE_W-1:0] v);
		@(negedge clk);
		while (idle_on && $urandom_range(99) < 33) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid   <= 1'b1;
		op         <= o;
		position   <= p;
		item_value <= v;
		do @(posedge clk); while (!in_ready);
		pending_results.push_back(predict_response(o, p, v));
	endtask

	// Drop valid before any wait that is not another send
	task automatic release_bus();
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	task automatic wait_all_results();
		release_bus();
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_empty_list();
		send_request(OP_READ, 6'd0, 32'sd0);
		send_request(OP_READ, 6'd63, -32'sd1);
		send_request(OP_FIND, 6'd0, 32'sd0);
		send_request(OP_DELETE, 6'd21, 32'sd5);
		send_request(OP_INSERT, 6'd1, 32'sd7);
		send_request(OP_INSERT, 6'd63, 32'sd7);
	endtask

	task automatic test_basic_ops();
		send_request(OP_INSERT, 6'd0, 32'sh7fff_ffff);
		send_request(OP_INSERT, 6'd1, 32'sh8000_0000);
		send_request(OP_INSERT, 6'd1, -32'sd1);
		send_request(OP_INSERT, 6'd0, 32'sd0);
		send_request(OP_INSERT, 6'd4, 32'sh7fff_ffff);
		send_request(OP_FIND, 6'd0, 32'sh7fff_ffff);
		send_request(OP_FIND, 6'd42, 32'sh8000_0000);
		for (int k = 0; k <= 5; k++)
			send_request(OP_READ, POS_W'(k), 32'sd0);
		send_request(OP_DELETE, 6'd0, 32'sh7fff_ffff);
		send_request(OP_FIND, 6'd0, 32'sh7fff_ffff);
		send_request(OP_DELETE, 6'd63, 32'sd0);
		send_request(OP_READ, 6'd0, 32'sd0);
		send_request(OP_FIND, 6'd0, 32'sd12345);
	endtask

	task automatic test_fill_and_drain();
		logic signed [VALUE_W-1:0] v;
		while (list_len < DEPTH)
			send_request(OP_INSERT, POS_W'($urandom_range(list_len)), $urandom);
		send_request(OP_INSERT, 6'd0, 32'sd9);
		send_request(OP_INSERT, 6'd40, 32'sd9);
		send_request(OP_FIND, 6'd0, list_mem[DEPTH-1]);
		send_request(OP_READ, 6'd31, 32'sd0);
		send_request(OP_READ, 6'd32, 32'sd0);
		while (list_len > 0) begin
			v = list_mem[$urandom_range(list_len - 1)];
			send_request(OP_DELETE, POS_W'($urandom), v);
		end
	endtask

	task automatic test_random_traffic(input int n_items);
		int mode;
		int r;
		op_t o;
		logic [POS_W-1:0] p;
		mode = 2;
		for (int i = 0; i < n_items; i++) begin
			// alternate growing, shrinking and mixed stretches
			if (i % 100 == 0)
				mode = $urandom_range(2);
			r = $urandom_range(99);
			if (r < 5) begin
				send_request(op_t'($urandom_range(3)), POS_W'($urandom), $urandom);
				continue;
			end
			r = $urandom_range(99);
			if (mode == 0)
				o = (r < 65) ? OP_INSERT : (r < 75) ? OP_DELETE : (r < 88) ? OP_FIND : OP_READ;
			else if (mode == 1)
				o = (r < 20) ? OP_INSERT : (r < 65) ? OP_DELETE : (r < 82) ? OP_FIND : OP_READ;
			else
				o = (r < 35) ? OP_INSERT : (r < 55) ? OP_DELETE : (r < 75) ? OP_FIND : OP_READ;
			r = $urandom_range(99);
			if (o == OP_INSERT && r < 80)
				p = POS_W'($urandom_range(list_len));
			else if (o == OP_READ && r < 80 && list_len > 0)
				p = POS_W'($urandom_range(list_len - 1));
			else if (r < 90 && list_len < 63)
				p = POS_W'($urandom_range(63, list_len + 1));
			else
				p = POS_W'($urandom);
			send_request(o, p, pick_value());
		end
	endtask

	// Stall the receiver long enough for the block to fill and hold its input
	task automatic test_receiver_hold();
		hold_req = 1'b1;
		test_random_traffic(24);
	endtask

	task automatic test_drain_pause();
		wait_all_results();
		test_random_traffic(20);
	endtask

	task automatic test_no_idle_burst();
		idle_on = 1'b0;
		test_random_traffic(200);
		idle_on = 1'b1;
	endtask

	initial begin
		int stall_left;
		stall_left = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				stall_left = HOLD_CYCLES;
				hold_req = 1'b0;
			end
			if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else begin
				out_ready <= !(idle_on && $urandom_range(99) < 33);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$error("result transaction with no request outstanding");
				mismatch_count++;
			end else begin
				check_want = pending_results.pop_front();
				if (status !== check_want.status) begin
					$error("status: expected %0d, got %0d", check_want.status, status);
					mismatch_count++;
				end
				if (found_index !== check_want.found_index) begin
					$error("found_index: expected %0d, got %0d",
						check_want.found_index, found_index);
					mismatch_count++;
				end
				if (read_data !== check_want.read_data) begin
					$error("read_data: expected %0d, got %0d",
						check_want.read_data, read_data);
					mismatch_count++;
				end
				if (entry_count !== check_want.entry_count) begin
					$error("entry_count: expected %0d, got %0d",
						check_want.entry_count, entry_count);
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		op = OP_INSERT;
		position = '0;
		item_value = '0;
		list_len = 0;
		mismatch_count = 0;
		idle_on = 1'b1;
		hold_req = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_empty_list();
		test_basic_ops();
		test_fill_and_drain();
		test_receiver_hold();
		test_drain_pause();
		test_random_traffic(450);
		test_no_idle_burst();
		test_random_traffic(450);

		wait_all_results();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
